// File: design/mswo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswo_pkg
// Shared types, register codes and the sine table generator for the
// multi-shape waveform oscillator.
// ----------------------------------------------------------------------------
package mswo_pkg;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int COUNT_BITS    = 32;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_TUNING_WORD  = 2'd0;
  localparam cfg_idx_t REG_WAVE_SHAPE   = 2'd1;
  localparam cfg_idx_t REG_SAMPLE_COUNT = 2'd2;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SAWTOOTH = 2'd3
  } shape_e;

  // pi/2 in unsigned Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Unsigned restoring division, shift and subtract
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry k, Taylor series to x^11 in Q30, rounded and
  // saturated to full scale minus one. Evaluated at elaboration only.
  function automatic logic [63:0] sine_entry(input int unsigned k,
                                             input int unsigned addr_bits,
                                             input int unsigned sample_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] fs;
    logic [63:0] div;
    x   = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
    x2  = (x * x) >> 30;
    term = x;
    sum  = x;
    fs   = 64'd1 << (sample_bits - 1);
    for (int n = 1; n <= 5; n++) begin
      div  = 64'((2 * n) * (2 * n + 1));
      term = udiv64((term * x2) >> 30, div);
      if (n[0]) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * fs + (64'd1 << 29)) >> 30;
    if (v > fs - 64'd1) begin
      v = fs - 64'd1;
    end
    return v;
  endfunction

endpackage

// File: design/mswo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswo_if
// Valid/ready channels of the oscillator: tick requests in, samples out.
// ----------------------------------------------------------------------------
interface mswo_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mswo_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: design/multi_shape_waveform_oscillator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_shape_waveform_oscillator_core
// Phase-accumulator oscillator: sine, square, triangle and sawtooth samples,
// with a run counter flagging the last sample of each run.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload               Handshake
//  in_ch     in   restart               valid / ready
//  out_ch    out  sample, last          valid / ready
//  cfg       in   cfg_idx_i/cfg_wdata_i cfg_we_i, no back-pressure
//
//  One item per cycle while out_ch drains; result is registered, valid the cycle after accept.
//  The sine quarter table is a registered ROM, addressed from the next phase.
//  Input ready while the output register is empty or being drained.
//  Reset clears phase, run counter, tuning word, ROM register and output valid; shape to sine, count to 1.
// ----------------------------------------------------------------------------
module multi_shape_waveform_oscillator_core
  import mswo_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  cfg_idx_t                 cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  mswo_in_if.sink                  in_ch,
  mswo_out_if.source               out_ch
);

  localparam int TAB_N = 1 << TABLE_ADDR_BITS;
  localparam int ROM_W = SAMPLE_BITS - 1;
  localparam int PAD   = SAMPLE_BITS + 1;

  typedef logic [ROM_W-1:0] rom_t [TAB_N+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= TAB_N; k++) begin
      r[k] = ROM_W'(sine_entry(k, TABLE_ADDR_BITS, SAMPLE_BITS));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [31:0]           tuning_q;
  shape_e                shape_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [COUNT_BITS-1:0] index_q, index_d;
  logic [ROM_W-1:0]      rom_q;
  logic                  out_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                  last_q, last_d;

  logic                  accept;
  logic                  restart;
  logic [PHASE_BITS-1:0] phase_eff;
  logic [COUNT_BITS-1:0] index_eff;
  logic [COUNT_BITS-1:0] count_eff;
  logic [COUNT_BITS:0]   index_inc;
  logic [PHASE_BITS+PAD-1:0] phase_ext;
  logic [SAMPLE_BITS:0]  tri_u;
  logic [SAMPLE_BITS:0]  tri_d;
  logic [SAMPLE_BITS-1:0] saw_u;
  logic [SAMPLE_BITS-1:0] sine_pos;
  logic [TABLE_ADDR_BITS-1:0] rom_idx;
  logic [TABLE_ADDR_BITS:0]   rom_addr;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign restart     = in_ch.restart;

  // Effective state for this tick
  assign phase_eff = restart ? '0 : phase_q;
  assign index_eff = restart ? '0 : index_q;
  assign count_eff = (count_q == '0) ? COUNT_BITS'(1) : count_q;
  assign index_inc = {1'b0, index_eff} + (COUNT_BITS+1)'(1);
  assign last_d    = index_inc >= {1'b0, count_eff};

  assign phase_ext = {phase_eff, PAD'(0)};
  assign tri_u     = phase_ext[PHASE_BITS+PAD-1 -: SAMPLE_BITS+1];
  assign saw_u     = phase_ext[PHASE_BITS+PAD-1 -: SAMPLE_BITS];
  assign tri_d     = tri_u[SAMPLE_BITS] ? (~tri_u + (SAMPLE_BITS+1)'(1)) : tri_u;
  assign sine_pos  = {1'b0, rom_q};

  always_comb begin
    sample_d = '0;
    case (shape_q)
      SHAPE_SINE: begin
        if (restart) begin
          sample_d = '0;
        end else if (phase_q[PHASE_BITS-1]) begin
          sample_d = -$signed(sine_pos);
        end else begin
          sample_d = $signed(sine_pos);
        end
      end
      SHAPE_SQUARE: begin
        if (phase_eff != '0 && !phase_eff[PHASE_BITS-1]) begin
          sample_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
          sample_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
      end
      SHAPE_TRIANGLE: begin
        if (tri_d[SAMPLE_BITS]) begin
          sample_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
          sample_d = {~tri_d[SAMPLE_BITS-1], tri_d[SAMPLE_BITS-2:0]};
        end
      end
      SHAPE_SAWTOOTH: begin
        sample_d = {~saw_u[SAMPLE_BITS-1], saw_u[SAMPLE_BITS-2:0]};
      end
      default: begin
        sample_d = '0;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    index_d = index_q;
    if (accept) begin
      if (last_d) begin
        phase_d = '0;
        index_d = '0;
      end else begin
        phase_d = phase_eff + PHASE_BITS'(tuning_q);
        index_d = index_inc[COUNT_BITS-1:0];
      end
    end
  end

  // Table address for the phase of the next tick, mirrored in odd quadrants
  assign rom_idx  = phase_d[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign rom_addr = phase_d[PHASE_BITS-2] ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, rom_idx})
                                          : {1'b0, rom_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuning_q    <= '0;
      shape_q     <= SHAPE_SINE;
      count_q     <= COUNT_BITS'(1);
      phase_q     <= '0;
      index_q     <= '0;
      rom_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TUNING_WORD:  tuning_q <= cfg_wdata_i;
          REG_WAVE_SHAPE:   shape_q  <= shape_e'(cfg_wdata_i[1:0]);
          REG_SAMPLE_COUNT: count_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      phase_q     <= phase_d;
      index_q     <= index_d;
      rom_q       <= SINE_ROM[rom_addr];
      out_valid_q <= accept || (out_valid_q && !out_ch.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_d;
      last_q   <= last_d;
    end
  end

  assign out_ch.valid  = out_valid_q;
  assign out_ch.sample = sample_q;
  assign out_ch.last   = last_q;

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_d |=> phase_q == '0 && index_q == '0)
    else $error("run end did not clear phase and counter");

  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item produced no result");

  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !restart && !last_d |=>
      phase_q == $past(phase_q + PHASE_BITS'(tuning_q)))
    else $error("phase did not advance by the tuning word");

endmodule
